FILE: rtl/core/dse_pkg.sv
// Shared types and constants of the delimited substream extractor.
package dse_pkg;

   localparam int DELIM_MAX_DEFAULT = 8;

   typedef enum logic [0:0] {
      CMD_DATA = 1'b0,
      CMD_END  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_DELIM  = 2'd1,
      KIND_SOURCE = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      CSR_DELIM_BYTES  = 1'b0,
      CSR_DELIM_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [63:0] delim_bytes;
      logic [3:0]  delim_length;
   } cfg_type;

   typedef struct packed {
      logic     load;
      logic     has_marker;
      kind_type marker_kind;
   } load_ctrl_type;

endpackage

FILE: rtl/core/dse_step.sv
// Window state and combinational delimiter match for one input item.
module dse_step #(
   parameter int DELIM_MAX = 8,
   localparam int IDX_W = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1,
   localparam int CNT_W = $clog2(DELIM_MAX + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  dse_pkg::req_item_type       item,
   input  dse_pkg::cfg_type            cfg,
   output dse_pkg::load_ctrl_type      ld_ctrl,
   output logic [DELIM_MAX-1:0][7:0]   ld_bytes,
   output logic [IDX_W-1:0]            ld_start,
   output logic [CNT_W-1:0]            ld_count
);
   import dse_pkg::*;

   // window is right aligned: the newest held byte sits in the top entry
   logic [DELIM_MAX-1:0][7:0] win_ff, win_in;
   logic [IDX_W-1:0]          fill_ff, fill_in;
   logic                      finished_ff, finished_in;

   logic [DELIM_MAX-1:0][7:0] cand;
   logic [DELIM_MAX:0]        match;
   logic [CNT_W-1:0]          fill_ext, n, len_eff, k_max, keep, start_full;
   logic                      full;

   always_comb begin
      for (int p = 0; p < DELIM_MAX - 1; p++) begin
         cand[p] = win_ff[p + 1];
      end
      cand[DELIM_MAX-1] = item.data_byte;
   end

   always_comb begin
      fill_ext = CNT_W'(fill_ff);
      n        = fill_ext + CNT_W'(1);
      if (cfg.delim_length == 4'd0) begin
         len_eff = CNT_W'(1);
      end else if (32'(cfg.delim_length) > DELIM_MAX) begin
         len_eff = CNT_W'(DELIM_MAX);
      end else begin
         len_eff = CNT_W'(cfg.delim_length);
      end
   end

   // tail of length k against the first k delimiter bytes
   always_comb begin
      match[0] = 1'b1;
      for (int k = 1; k <= DELIM_MAX; k++) begin
         match[k] = 1'b1;
         for (int j = 0; j < k; j++) begin
            if (cand[DELIM_MAX - k + j] != cfg.delim_bytes[8*j +: 8]) begin
               match[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      full  = (n >= len_eff) && match[len_eff];
      k_max = (n < len_eff - CNT_W'(1)) ? n : len_eff - CNT_W'(1);
      keep  = '0;
      for (int k = 1; k < DELIM_MAX; k++) begin
         if ((CNT_W'(k) <= k_max) && match[k]) begin
            keep = CNT_W'(k);
         end
      end
      start_full = CNT_W'(DELIM_MAX) - n;
   end

   // next state
   always_comb begin
      win_in      = win_ff;
      fill_in     = fill_ff;
      finished_in = finished_ff;
      if (take && !finished_ff) begin
         case (item.cmd)
            CMD_END: begin
               fill_in     = '0;
               finished_in = 1'b1;
            end
            CMD_DATA: begin
               win_in = cand;
               if (full) begin
                  fill_in     = '0;
                  finished_in = 1'b1;
               end else begin
                  fill_in = keep[IDX_W-1:0];
               end
            end
            default: begin
               finished_in = finished_ff;
            end
         endcase
      end
   end

   // load for the result buffer
   always_comb begin
      ld_ctrl.load        = take;
      ld_ctrl.has_marker  = 1'b0;
      ld_ctrl.marker_kind = KIND_DATA;
      ld_bytes            = cand;
      ld_start            = start_full[IDX_W-1:0];
      ld_count            = '0;
      if (!finished_ff) begin
         case (item.cmd)
            CMD_END: begin
               ld_bytes            = win_ff;
               ld_start            = IDX_W'(CNT_W'(DELIM_MAX) - fill_ext);
               ld_count            = fill_ext;
               ld_ctrl.has_marker  = 1'b1;
               ld_ctrl.marker_kind = KIND_SOURCE;
            end
            CMD_DATA: begin
               if (full) begin
                  ld_count            = n - len_eff;
                  ld_ctrl.has_marker  = 1'b1;
                  ld_ctrl.marker_kind = KIND_DELIM;
               end else begin
                  ld_count = n - keep;
               end
            end
            default: begin
               ld_count = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         fill_ff     <= '0;
         finished_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         finished_ff <= finished_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= DELIM_MAX - 1)
      else $error("held byte count exceeds delimiter length minus one");

   assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished flag cleared without reset");

   assert property (@(posedge clock) disable iff (reset)
      (take && finished_ff) |-> (ld_count == '0 && !ld_ctrl.has_marker))
      else $error("results loaded after the stream ended");

endmodule

FILE: rtl/core/dse_emit.sv
// Result buffer that hands out one result item per cycle while rsp_ready is high.
module dse_emit #(
   parameter int DELIM_MAX = 8,
   localparam int IDX_W = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1,
   localparam int CNT_W = $clog2(DELIM_MAX + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dse_pkg::load_ctrl_type      ld_ctrl,
   input  logic [DELIM_MAX-1:0][7:0]   ld_bytes,
   input  logic [IDX_W-1:0]            ld_start,
   input  logic [CNT_W-1:0]            ld_count,
   output logic                        can_load,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output dse_pkg::rsp_item_type       rsp_payload
);
   import dse_pkg::*;

   logic [DELIM_MAX-1:0][7:0] bytes_ff, bytes_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic [CNT_W-1:0]          left_ff, left_in;
   logic                      mark_ff, mark_in;
   kind_type                  mkind_ff, mkind_in;
   logic                      empty, fire;

   always_comb begin
      empty     = (left_ff == '0) && !mark_ff;
      rsp_valid = !empty;
      if (left_ff != '0) begin
         rsp_payload.out_byte = bytes_ff[ptr_ff];
         rsp_payload.kind     = KIND_DATA;
         rsp_payload.last     = (left_ff == CNT_W'(1)) && !mark_ff;
      end else begin
         rsp_payload.out_byte = 8'd0;
         rsp_payload.kind     = mkind_ff;
         rsp_payload.last     = 1'b1;
      end
      fire     = rsp_valid && rsp_ready;
      can_load = empty || (fire && rsp_payload.last);
   end

   always_comb begin
      bytes_in = bytes_ff;
      ptr_in   = ptr_ff;
      left_in  = left_ff;
      mark_in  = mark_ff;
      mkind_in = mkind_ff;
      if (ld_ctrl.load) begin
         bytes_in = ld_bytes;
         ptr_in   = ld_start;
         left_in  = ld_count;
         mark_in  = ld_ctrl.has_marker;
         mkind_in = ld_ctrl.marker_kind;
      end else if (fire) begin
         if (left_ff != '0) begin
            left_in = left_ff - CNT_W'(1);
            ptr_in  = ptr_ff + IDX_W'(1);
         end else begin
            mark_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      ptr_ff   <= ptr_in;
      mkind_ff <= mkind_in;
      if (reset) begin
         left_ff <= '0;
         mark_ff <= 1'b0;
      end else begin
         left_ff <= left_in;
         mark_ff <= mark_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind != KIND_DATA) |-> rsp_payload.last)
      else $error("end marker not flagged as last");

   assert property (@(posedge clock) disable iff (reset)
      ld_ctrl.load |-> can_load)
      else $error("result buffer overwritten before drained");

   assert property (@(posedge clock) disable iff (reset)
      (fire && !rsp_payload.last) |=> rsp_valid)
      else $error("results of an item lost mid-sequence");

endmodule

FILE: rtl/core/delimited_substream_extractor.sv
// Top level of the delimited substream extractor: input register, CSRs, step and result buffer.
//
// Passes a byte stream through until the first occurrence of a delimiter of
// 1 to DELIM_MAX bytes (csr index 0: delimiter bytes, first byte in bits 7:0;
// index 1: delimiter length in bits 3:0, 0 read as 1 and values above
// DELIM_MAX read as DELIM_MAX). Bytes that may still start a delimiter are
// held back in a window. On a match the delimiter is dropped and an end item
// of kind 1 follows; on a source-ended command the held bytes are flushed and
// an end item of kind 2 follows. After either end every input item is taken
// and gives nothing until reset. The last result of each input item carries
// last = 1; an item that is held in full gives no result. Input items are
// taken at one per cycle while the result buffer can load: the window
// compare is a single parallel pass between the input register and the
// result buffer. The result port hands out one item per cycle while
// rsp_ready is high, and the next input is taken in the cycle the final
// result of the previous one leaves. The first result is offered once its
// item has passed the input register and been loaded into the result
// buffer. Configuration writes are always taken and must only be issued
// while the block is idle.
module delimited_substream_extractor #(
   parameter int DELIM_MAX = dse_pkg::DELIM_MAX_DEFAULT,
   localparam int IDX_W = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1,
   localparam int CNT_W = $clog2(DELIM_MAX + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dse_pkg::req_item_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dse_pkg::rsp_item_type rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  dse_pkg::csr_index_type csr_index,
   input  logic [63:0]           csr_data
);
   import dse_pkg::*;

   // input register: holds one item until the result buffer can take its results
   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff, in_item_in;
   cfg_type       cfg_ff, cfg_in;

   logic                      can_load, take;
   load_ctrl_type             ld_ctrl;
   logic [DELIM_MAX-1:0][7:0] ld_bytes;
   logic [IDX_W-1:0]          ld_start;
   logic [CNT_W-1:0]          ld_count;

   // advance the held item whenever the buffer frees up; refill in the same cycle
   always_comb begin
      take        = in_valid_ff && can_load;
      req_ready   = !in_valid_ff || take;
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_item_in  = req_payload;
      end
   end

   // CSR writes: always ready
   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DELIM_BYTES:  cfg_in.delim_bytes  = csr_data;
            CSR_DELIM_LENGTH: cfg_in.delim_length = csr_data[3:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (reset) begin
         in_valid_ff         <= 1'b0;
         cfg_ff.delim_bytes  <= '0;
         cfg_ff.delim_length <= 4'd1;
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
      end
   end

   dse_step #(.DELIM_MAX(DELIM_MAX)) u_step (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .item     (in_item_ff),
      .cfg      (cfg_ff),
      .ld_ctrl  (ld_ctrl),
      .ld_bytes (ld_bytes),
      .ld_start (ld_start),
      .ld_count (ld_count)
   );

   dse_emit #(.DELIM_MAX(DELIM_MAX)) u_emit (
      .clock       (clock),
      .reset       (reset),
      .ld_ctrl     (ld_ctrl),
      .ld_bytes    (ld_bytes),
      .ld_start    (ld_start),
      .ld_count    (ld_count),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !take) |=> in_valid_ff)
      else $error("held input item dropped before processing");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !take) |=> $stable(in_item_ff))
      else $error("held input item changed while waiting");

   assert property (@(posedge clock) disable iff (reset)
      take |-> ld_ctrl.load)
      else $error("processed item did not load the result buffer");

endmodule
